### rtl/sha256_message_digest_defines.svh
// Assertion macros shared by the digest RTL
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH
`ifndef ASSERT_OFF
// check a property outside reset
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every edge
`define SHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/sha256md_pkg.sv
package sha256md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [7:0][31:0] hash_t;

  // one queued block and whether it closes the message
  typedef struct packed {
    block_t words;
    logic   final_blk;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {F_IN, F_PAD, F_LEN} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_OUT} back_state_t;

  localparam int QDEPTH = 2;
  localparam logic [1:0] Q_FULL_CNT = 2'd2;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // word 0 sits at index 0
  localparam hash_t HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t ch(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

### rtl/sha256md_front.sv
module sha256md_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_message_byte,
  input  logic                  in_has_byte,
  input  logic                  in_last_byte,
  input  sha256md_pkg::q_stat_t q_stat_i,
  output logic                  push_o,
  output sha256md_pkg::qent_t   push_data_o
);

  sha256md_pkg::front_state_t state_r, state_nxt;
  sha256md_pkg::block_t       buf_r, buf_nxt;
  sha256md_pkg::block_t       buf_byte, buf_pad, buf_len;
  logic [5:0]                 pos_r, pos_nxt;
  logic [63:0]                count_r, count_nxt;
  logic                       accept;

  assign accept = in_valid && !in_stall;

  // hold requests while padding or while the queue is full
  always_comb begin
    in_stall = (state_r != sha256md_pkg::F_IN) || q_stat_i.full;
  end

  // merge candidate bytes into the block buffer
  always_comb begin
    buf_byte = buf_r;
    buf_byte[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] = in_message_byte;
    buf_pad = buf_r;
    buf_pad[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] = sha256md_pkg::PAD_BYTE;
    buf_len = buf_r;
    buf_len[14] = count_r[63:32];
    buf_len[15] = count_r[31:0];
  end

  // next state and block push
  always_comb begin
    state_nxt   = state_r;
    buf_nxt     = buf_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    push_o      = 1'b0;
    push_data_o = '{words: buf_r, final_blk: 1'b0};
    case (state_r)
      sha256md_pkg::F_IN: begin
        if (accept) begin
          if (in_has_byte) begin
            buf_nxt   = buf_byte;
            pos_nxt   = pos_r + 6'd1;
            count_nxt = count_r + 64'd8;
            if (pos_r == 6'd63) begin
              push_o      = 1'b1;
              push_data_o = '{words: buf_byte, final_blk: 1'b0};
              buf_nxt     = '0;
            end
          end
          if (in_last_byte) state_nxt = sha256md_pkg::F_PAD;
        end
      end
      sha256md_pkg::F_PAD: begin
        if (!q_stat_i.full) begin
          buf_nxt   = buf_pad;
          pos_nxt   = pos_r + 6'd1;
          state_nxt = sha256md_pkg::F_LEN;
          // no room left for the length: close this block first
          if (pos_r >= 6'd56) begin
            push_o      = 1'b1;
            push_data_o = '{words: buf_pad, final_blk: 1'b0};
            buf_nxt     = '0;
          end
        end
      end
      sha256md_pkg::F_LEN: begin
        if (!q_stat_i.full) begin
          push_o      = 1'b1;
          push_data_o = '{words: buf_len, final_blk: 1'b1};
          buf_nxt     = '0;
          pos_nxt     = '0;
          count_nxt   = '0;
          state_nxt   = sha256md_pkg::F_IN;
        end
      end
      default: state_nxt = sha256md_pkg::F_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256md_pkg::F_IN;
      buf_r   <= '0;
      pos_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      buf_r   <= buf_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/sha256md_queue.sv
`include "sha256_message_digest_defines.svh"
module sha256md_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  sha256md_pkg::qent_t   push_data_i,
  input  logic                  pop_i,
  output sha256md_pkg::qent_t   pop_data_o,
  output sha256md_pkg::q_stat_t q_stat_o
);

  sha256md_pkg::qent_t mem_r [sha256md_pkg::QDEPTH];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          cnt_r;

  assign pop_data_o     = mem_r[rd_ptr_r];
  assign q_stat_o.full  = (cnt_r == sha256md_pkg::Q_FULL_CNT);
  assign q_stat_o.empty = (cnt_r == 2'd0);

  // store pushed blocks
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= push_data_i;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (pop_i) rd_ptr_r <= ~rd_ptr_r;
      case ({push_i, pop_i})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `SHA_ASSERT(a_no_overflow, push_i |-> !q_stat_o.full, "push into full queue")
  `SHA_ASSERT(a_no_underflow, pop_i |-> !q_stat_o.empty, "pop from empty queue")
  `SHA_ASSERT(a_cnt_range, cnt_r != 2'd3, "queue count out of range")

endmodule

### rtl/sha256md_back.sv
`include "sha256_message_digest_defines.svh"
module sha256md_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256md_pkg::q_stat_t q_stat_i,
  output logic                  pop_o,
  input  sha256md_pkg::qent_t   pop_data_i,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_digest_word,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word
);

  sha256md_pkg::back_state_t state_r, state_nxt;
  sha256md_pkg::hash_t       hash_r, hash_nxt;
  sha256md_pkg::hash_t       v_r, v_nxt;
  sha256md_pkg::block_t      w_r, w_nxt;
  logic [5:0]                round_r, round_nxt;
  logic                      final_r, final_nxt;
  logic [2:0]                idx_r, idx_nxt;
  sha256md_pkg::word_t       t1, t2, w_new;

  // round datapath and schedule extension
  always_comb begin
    t1 = v_r[7] + sha256md_pkg::bsig1(v_r[4]) + sha256md_pkg::ch(v_r[4], v_r[5], v_r[6])
       + sha256md_pkg::round_k(round_r) + w_r[0];
    t2 = sha256md_pkg::bsig0(v_r[0]) + sha256md_pkg::maj(v_r[0], v_r[1], v_r[2]);
    w_new = sha256md_pkg::ssig1(w_r[14]) + w_r[9] + sha256md_pkg::ssig0(w_r[1]) + w_r[0];
  end

  // next state and register updates
  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    round_nxt = round_r;
    final_nxt = final_r;
    idx_nxt   = idx_r;
    case (state_r)
      sha256md_pkg::B_IDLE: begin
        if (!q_stat_i.empty) begin
          w_nxt     = pop_data_i.words;
          final_nxt = pop_data_i.final_blk;
          v_nxt     = hash_r;
          round_nxt = '0;
          state_nxt = sha256md_pkg::B_ROUND;
        end
      end
      sha256md_pkg::B_ROUND: begin
        v_nxt[7]  = v_r[6];
        v_nxt[6]  = v_r[5];
        v_nxt[5]  = v_r[4];
        v_nxt[4]  = v_r[3] + t1;
        v_nxt[3]  = v_r[2];
        v_nxt[2]  = v_r[1];
        v_nxt[1]  = v_r[0];
        v_nxt[0]  = t1 + t2;
        w_nxt     = {w_new, w_r[15:1]};
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) state_nxt = sha256md_pkg::B_ADD;
      end
      sha256md_pkg::B_ADD: begin
        for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + v_r[i];
        idx_nxt   = '0;
        state_nxt = final_r ? sha256md_pkg::B_OUT : sha256md_pkg::B_IDLE;
      end
      sha256md_pkg::B_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          // drop the chaining value once the last word is taken
          if (idx_r == 3'd7) begin
            hash_nxt  = sha256md_pkg::HASH_INIT;
            state_nxt = sha256md_pkg::B_IDLE;
          end
        end
      end
      default: state_nxt = sha256md_pkg::B_IDLE;
    endcase
  end

  // drive the queue pop and the result port
  always_comb begin
    pop_o           = (state_r == sha256md_pkg::B_IDLE) && !q_stat_i.empty;
    out_valid       = (state_r == sha256md_pkg::B_OUT);
    out_digest_word = hash_r[idx_r];
    out_word_index  = idx_r;
    out_last_word   = (idx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256md_pkg::B_IDLE;
      hash_r  <= sha256md_pkg::HASH_INIT;
      v_r     <= '0;
      round_r <= '0;
      final_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hash_r  <= hash_nxt;
      v_r     <= v_nxt;
      round_r <= round_nxt;
      final_r <= final_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  `SHA_ASSERT(a_round_end, (state_r == sha256md_pkg::B_ROUND && round_r == 6'd63) |=> (state_r == sha256md_pkg::B_ADD), "round 63 not followed by add")
  `SHA_ASSERT(a_hash_restart, (out_valid && !out_stall && idx_r == 3'd7) |=> (state_r == sha256md_pkg::B_IDLE && hash_r == sha256md_pkg::HASH_INIT), "hash not restarted after digest")
  `SHA_ASSERT(a_out_only_final, $rose(out_valid) |-> $past(final_r), "digest shown for a non-final block")

endmodule

### rtl/sha256_message_digest.sv
// channel   ports                                                  direction
// in        in_valid in_stall in_message_byte in_has_byte          request in
//           in_last_byte
// out       out_valid out_stall out_digest_word out_word_index     request out
//           out_last_word
//
// One byte request per cycle is taken while the block queue has room and no
// padding is under way. Each 64-byte block passes through the compression unit
// as a load, one round per cycle and a hash add; the single round unit sets the block rate.
// A final request passes through the padding and length states before input
// resumes, and waits in them while the queue is full.
// Reset is synchronous, active low, and restores the initial hash.
// The queue holds two blocks, so input stalls when both are waiting, and also while padding.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256md_pkg::q_stat_t q_stat;
  sha256md_pkg::qent_t   push_data, pop_data;
  logic                  push, pop;

  sha256md_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_byte (in_message_byte),
    .in_has_byte     (in_has_byte),
    .in_last_byte    (in_last_byte),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  sha256md_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  sha256md_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat_i        (q_stat),
    .pop_o           (pop),
    .pop_data_i      (pop_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_message_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // predictor state
  word_t       chain [8];
  word_t       blk [16];
  int          byte_pos;
  logic [63:0] bit_count;

  digest_out_t digest_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          gaps_on = 1'b1;

  sha256_message_digest dut (.*);

  always #6 clk = ~clk;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one full compression of blk into chain, then clear the block
  function automatic void compress_block();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) w[t] = blk[t];
      else w[t] = w[t-16] + w[t-7]
        + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
        + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    foreach (blk[i]) blk[i] = '0;
  endfunction

  function automatic void clear_digest();
    foreach (chain[i]) chain[i] = IV[i];
    foreach (blk[i]) blk[i] = '0;
    byte_pos = 0;
    bit_count = '0;
  endfunction

  function automatic void put_byte(logic [7:0] v);
    int sh;
    sh = (3 - (byte_pos % 4)) * 8;
    blk[byte_pos / 4] = (blk[byte_pos / 4] & ~(32'hff << sh)) | (word_t'(v) << sh);
    byte_pos = (byte_pos + 1) % 64;
  endfunction

  // advance the predictor by one request, queueing any digest words
  function automatic void predict_digest(logic [7:0] b, logic has, logic last);
    digest_out_t r;
    if (has) begin
      put_byte(b);
      bit_count += 64'd8;
      if (byte_pos == 0) compress_block();
    end
    if (!last) return;
    put_byte(8'h80);
    if (byte_pos > 56 || byte_pos == 0) begin
      compress_block();
      byte_pos = 0;
    end
    blk[14] = bit_count[63:32];
    blk[15] = bit_count[31:0];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      r.digest_word = chain[k];
      r.word_index = 3'(k);
      r.last_word = (k == 7);
      digest_q = {digest_q, r};
    end
    clear_digest();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one request, holding it until accepted
  task automatic send_request(logic [7:0] b, logic has, logic last);
    in_valid <= 1'b1;
    in_message_byte <= b;
    in_has_byte <= has;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(b, has, last);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic finish_sending();
    in_valid <= 1'b0;
  endtask

  task automatic send_message(int len, bit empty_last);
    for (int i = 0; i < len; i++)
      send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_last);
    if (empty_last || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // check each digest word against the oldest expectation
  always @(posedge clk) begin
    digest_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", out_digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.digest_word)
          report_mismatch("digest_word", out_digest_word, want.digest_word);
        if (out_word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_word_index), 32'(want.word_index));
        if (out_last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_last_word), 32'(want.last_word));
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!gaps_on) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(8'h00, 1'b0, 1'b1);            // empty message
    send_request(8'h00, 1'b0, 1'b0);            // no-op request
    send_request(8'hff, 1'b1, 1'b1);            // single byte
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);            // "abc" with a no-op inside
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);            // last without a byte
  endtask

  // lengths near the padding boundaries
  task automatic test_block_edges();
    int lens [3] = '{55, 56, 63};
    foreach (lens[i]) send_message(lens[i], 1'b0);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 80) begin
      int len;
      len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : $urandom_range(1, 70);
      send_message(len, $urandom_range(0, 4) == 0);
      sent += len + 1;
    end
  endtask

  // hold off the receiver while the sender keeps going
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_off = 1'b1;
    fork
      begin
        send_message(64, 1'b0);
        send_message(64, 1'b0);
        send_message(16, 1'b0);
        finish_sending();
      end
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    gaps_on = 1'b1;
  endtask

  initial begin
    int waited;
    clear_digest();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_block_edges();
    test_backpressure();
    test_random();
    finish_sending();
    waited = 0;
    while (digest_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && digest_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sha256md_pkg.sv
rtl/sha256md_front.sv
rtl/sha256md_queue.sv
rtl/sha256md_back.sv
rtl/sha256_message_digest.sv
tb/testbench.sv
